// ===== sv/conv3x3_multichannel_stream_core_macros.svh =====
// ----------------------------------------------------------------------------
// conv3x3 stream core assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef CONV3X3_MULTICHANNEL_STREAM_CORE_MACROS_SVH
`define CONV3X3_MULTICHANNEL_STREAM_CORE_MACROS_SVH

// same-cycle implication, off while in reset
`define C3S_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c3s check failed");

// next-cycle implication, live during reset too
`define C3S_ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("c3s check failed");

`endif

// ===== sv/c3s_pkg.sv =====
// ----------------------------------------------------------------------------
// c3s_pkg
// shared constants and types of the 3x3 multichannel convolution core
// ----------------------------------------------------------------------------
package c3s_pkg;

  // default configuration of the core
  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_IN_CHANNELS  = 3;
  localparam int DEF_OUT_CHANNELS = 16;
  localparam int DEF_SAMPLE_BITS  = 16;

  // kernel geometry
  localparam int KSIZE = 3;
  localparam int KTAPS = KSIZE * KSIZE;
  localparam int FRAC_BITS = 8;

  // channels carried by the input beat
  localparam int PORT_CHANNELS = 3;

  // operation selector
  localparam logic [1:0] OP_PIXEL  = 2'd0;
  localparam logic [1:0] OP_WEIGHT = 2'd1;
  localparam logic [1:0] OP_BIAS   = 2'd2;

  // configuration register indexes
  localparam int REG_IDX_BITS = 2;
  localparam logic [REG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;

  // register reset values
  localparam logic [10:0] RST_WIDTH  = 11'd1024;
  localparam logic [15:0] RST_HEIGHT = 16'd1024;

  // pipeline tag of one channel result
  typedef struct packed {
    logic vld;
    logic last;
  } tag_t;

endpackage

// ===== sv/c3s_ram.sv =====
// ----------------------------------------------------------------------------
// c3s_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module c3s_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/c3s_window.sv =====
// ----------------------------------------------------------------------------
// c3s_window
// two line stores and a 3x3 tap window per input channel
// ----------------------------------------------------------------------------
module c3s_window #(
  parameter int MAX_WIDTH   = c3s_pkg::DEF_MAX_WIDTH,
  parameter int IN_CHANNELS = c3s_pkg::DEF_IN_CHANNELS,
  parameter int SAMPLE_BITS = c3s_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rd_go,
  input  logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] rd_col,
  input  logic                          wr_go,
  input  logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] wr_col,
  input  logic signed [SAMPLE_BITS-1:0] samples [IN_CHANNELS],
  output logic signed [SAMPLE_BITS-1:0] taps [IN_CHANNELS*c3s_pkg::KTAPS]
);

  localparam int RW = IN_CHANNELS * SAMPLE_BITS;
  localparam int K  = c3s_pkg::KSIZE;

  logic [RW-1:0] pix;
  logic [RW-1:0] line0_rd;
  logic [RW-1:0] line1_rd;
  logic signed [SAMPLE_BITS-1:0] win_r [IN_CHANNELS*c3s_pkg::KTAPS];

  // pack the new pixel
  for (genvar ic = 0; ic < IN_CHANNELS; ic++) begin : g_pack
    assign pix[ic*SAMPLE_BITS +: SAMPLE_BITS] = samples[ic];
  end

  // older line: takes the newer line's word
  c3s_ram #(.WIDTH(RW), .DEPTH(MAX_WIDTH)) u_line0 (
    .clk(clk), .wr_en(wr_go), .wr_addr(wr_col), .wr_data(line1_rd),
    .rd_en(rd_go), .rd_addr(rd_col), .rd_data(line0_rd)
  );

  // newer line: takes the current pixel
  c3s_ram #(.WIDTH(RW), .DEPTH(MAX_WIDTH)) u_line1 (
    .clk(clk), .wr_en(wr_go), .wr_addr(wr_col), .wr_data(pix),
    .rd_en(rd_go), .rd_addr(rd_col), .rd_data(line1_rd)
  );

  // shift window left, new column from line stores and pixel
  always_ff @(posedge clk) begin
    if (wr_go) begin
      for (int ic = 0; ic < IN_CHANNELS; ic++) begin
        for (int r = 0; r < K; r++) begin
          win_r[ic*9 + r*3 + 0] <= win_r[ic*9 + r*3 + 1];
          win_r[ic*9 + r*3 + 1] <= win_r[ic*9 + r*3 + 2];
        end
        win_r[ic*9 + 2] <= line0_rd[ic*SAMPLE_BITS +: SAMPLE_BITS];
        win_r[ic*9 + 5] <= line1_rd[ic*SAMPLE_BITS +: SAMPLE_BITS];
        win_r[ic*9 + 8] <= samples[ic];
      end
    end
  end

  assign taps = win_r;

endmodule

// ===== sv/c3s_lane.sv =====
// ----------------------------------------------------------------------------
// c3s_lane
// one kernel tap: weight store with one word per output channel and a Q8.8 multiplier
// ----------------------------------------------------------------------------
module c3s_lane #(
  parameter int OUT_CHANNELS = c3s_pkg::DEF_OUT_CHANNELS,
  parameter int SAMPLE_BITS  = c3s_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          wr_en,
  input  logic [(OUT_CHANNELS > 1 ? $clog2(OUT_CHANNELS) : 1)-1:0] wr_addr,
  input  logic signed [SAMPLE_BITS-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [(OUT_CHANNELS > 1 ? $clog2(OUT_CHANNELS) : 1)-1:0] rd_addr,
  input  logic signed [SAMPLE_BITS-1:0] tap,
  output logic [SAMPLE_BITS-1:0]        term
);

  logic [SAMPLE_BITS-1:0] wgt;
  logic signed [2*SAMPLE_BITS-1:0] prod;
  logic [SAMPLE_BITS-1:0] term_r;

  c3s_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(OUT_CHANNELS)) u_wgt (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(wgt)
  );

  // floor of the Q16.16 product back to Q8.8, wrapped
  assign prod = tap * $signed(wgt);

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= prod[SAMPLE_BITS+c3s_pkg::FRAC_BITS-1:c3s_pkg::FRAC_BITS];
    end
  end

  assign term = term_r;

endmodule

// ===== sv/c3s_merge.sv =====
// ----------------------------------------------------------------------------
// c3s_merge
// bias store and two-level adder tree over the lane terms
// ----------------------------------------------------------------------------
module c3s_merge #(
  parameter int IN_CHANNELS  = c3s_pkg::DEF_IN_CHANNELS,
  parameter int OUT_CHANNELS = c3s_pkg::DEF_OUT_CHANNELS,
  parameter int SAMPLE_BITS  = c3s_pkg::DEF_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic                   wr_en,
  input  logic [(OUT_CHANNELS > 1 ? $clog2(OUT_CHANNELS) : 1)-1:0] wr_addr,
  input  logic [SAMPLE_BITS-1:0] wr_data,
  input  logic                   rd_en,
  input  logic [(OUT_CHANNELS > 1 ? $clog2(OUT_CHANNELS) : 1)-1:0] rd_addr,
  input  logic [SAMPLE_BITS-1:0] terms [IN_CHANNELS*c3s_pkg::KTAPS],
  output logic [SAMPLE_BITS-1:0] total
);

  localparam int KT = c3s_pkg::KTAPS;

  logic [SAMPLE_BITS-1:0] bias_rd;
  logic [SAMPLE_BITS-1:0] bias_p2_r;
  logic [SAMPLE_BITS-1:0] bias_p3_r;
  logic [SAMPLE_BITS-1:0] part_nxt [IN_CHANNELS];
  logic [SAMPLE_BITS-1:0] part_r [IN_CHANNELS];
  logic [SAMPLE_BITS-1:0] total_nxt;
  logic [SAMPLE_BITS-1:0] total_r;

  c3s_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(OUT_CHANNELS)) u_bias (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(bias_rd)
  );

  // per input channel sums, modulo the sample width
  always_comb begin
    for (int ic = 0; ic < IN_CHANNELS; ic++) begin
      part_nxt[ic] = terms[ic*KT];
      for (int k = 1; k < KT; k++) begin
        part_nxt[ic] = part_nxt[ic] + terms[ic*KT + k];
      end
    end
  end

  // bias plus channel sums
  always_comb begin
    total_nxt = bias_p3_r;
    for (int ic = 0; ic < IN_CHANNELS; ic++) begin
      total_nxt = total_nxt + part_r[ic];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bias_p2_r <= bias_rd;
      bias_p3_r <= bias_p2_r;
      part_r    <= part_nxt;
      total_r   <= total_nxt;
    end
  end

  assign total = total_r;

endmodule

// ===== sv/conv3x3_multichannel_stream_core.sv =====
// ----------------------------------------------------------------------------
// conv3x3_multichannel_stream_core
// 3x3 valid convolution over a raster stream, one lane per kernel tap
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  in_     | in  | pixel, weight load or bias load, selected by tuser
//  out_    | out | one output channel result, tlast on the final channel
//  cfg_    | in  | register write: image width, image height
//
// Loads, and pixels in the first two rows or columns, start no issue. A
// pixel with results holds the input while the weight and bias store read
// port issues one channel per cycle unless the output buffer is full; the
// next beat is taken on the cycle of the last channel. Reset clears the
// counters, configuration and pipeline; stores are not cleared. A stalled
// output holds the pipeline once the 2-entry buffer fills.
module conv3x3_multichannel_stream_core #(
  parameter int MAX_WIDTH    = c3s_pkg::DEF_MAX_WIDTH,
  parameter int IN_CHANNELS  = c3s_pkg::DEF_IN_CHANNELS,
  parameter int OUT_CHANNELS = c3s_pkg::DEF_OUT_CHANNELS,
  parameter int SAMPLE_BITS  = c3s_pkg::DEF_SAMPLE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  // sample_ch0, sample_ch1, sample_ch2, target_out_channel, target_in_channel,
  // tap_row, tap_col, coef_value, zero fill
  input  logic [79:0] in_tdata,
  // operation
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_channel, feature_value, zero fill
  output logic [23:0] out_tdata,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [c3s_pkg::REG_IDX_BITS-1:0] cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int CW  = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1) > 11 ? $clog2(MAX_WIDTH + 1) : 11;
  localparam int OCW = OUT_CHANNELS > 1 ? $clog2(OUT_CHANNELS) : 1;
  localparam int NL  = IN_CHANNELS * c3s_pkg::KTAPS;
  localparam int PC  = c3s_pkg::PORT_CHANNELS;
  localparam logic [OCW-1:0] LAST_OC = OCW'(OUT_CHANNELS - 1);
  localparam logic [WW-1:0]  MAXW    = WW'(MAX_WIDTH);

  // input fields
  logic [1:0]  f_op;
  logic [15:0] f_smp [PC];
  logic [3:0]  f_toc;
  logic [1:0]  f_tic;
  logic [1:0]  f_tr;
  logic [1:0]  f_tc;
  logic [15:0] f_coef;

  assign f_op     = in_tuser;
  assign f_smp[0] = in_tdata[15:0];
  assign f_smp[1] = in_tdata[31:16];
  assign f_smp[2] = in_tdata[47:32];
  assign f_toc    = in_tdata[51:48];
  assign f_tic    = in_tdata[53:52];
  assign f_tr     = in_tdata[55:54];
  assign f_tc     = in_tdata[57:56];
  assign f_coef   = in_tdata[73:58];

  // configuration
  logic [10:0] img_w_r;
  logic [15:0] img_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= c3s_pkg::RST_WIDTH;
      img_h_r <= c3s_pkg::RST_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_addr)
        c3s_pkg::REG_WIDTH:  img_w_r <= cfg_wdata[10:0];
        c3s_pkg::REG_HEIGHT: img_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline enable, held by a full output buffer
  logic [1:0] q_cnt_r;
  logic       en;
  assign en = (q_cnt_r != 2'd2);

  // channel sequencer
  logic           seq_act_r;
  logic [OCW-1:0] oc_r;
  logic           seq_last;
  assign seq_last = (oc_r == LAST_OC);

  assign in_tready = en && !(seq_act_r && !seq_last);

  logic in_fire;
  logic is_pix;
  logic ld_w;
  logic ld_b;
  assign in_fire = in_tvalid && in_tready;
  assign is_pix  = in_fire && (f_op == c3s_pkg::OP_PIXEL);
  assign ld_b    = in_fire && (f_op == c3s_pkg::OP_BIAS) && (int'(f_toc) < OUT_CHANNELS);
  assign ld_w    = in_fire && (f_op == c3s_pkg::OP_WEIGHT) && (int'(f_toc) < OUT_CHANNELS)
                   && (int'(f_tic) < IN_CHANNELS) && (int'(f_tr) < c3s_pkg::KSIZE)
                   && (int'(f_tc) < c3s_pkg::KSIZE);

  // raster counters
  logic [CW-1:0] col_r;
  logic [15:0]   row_r;
  logic [WW-1:0] eff_w;
  logic [15:0]   eff_h;
  logic          has_out;

  always_comb begin
    eff_w = WW'(img_w_r);
    if (eff_w < WW'(3)) eff_w = WW'(3);
    if (eff_w > MAXW)   eff_w = MAXW;
    eff_h = (img_h_r < 16'd3) ? 16'd3 : img_h_r;
  end

  assign has_out = (row_r >= 16'd2) && (WW'(col_r) >= WW'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (is_pix) begin
      if (WW'(col_r) + WW'(1) >= eff_w) begin
        col_r <= '0;
        if (17'(row_r) + 17'd1 >= 17'(eff_h)) row_r <= '0;
        else                                   row_r <= row_r + 16'd1;
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // pixel stage in front of the window
  logic                          s0_vld_r;
  logic [CW-1:0]                 s0_col_r;
  logic signed [SAMPLE_BITS-1:0] s0_smp_r [IN_CHANNELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= is_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (is_pix) begin
      s0_col_r <= col_r;
      for (int ic = 0; ic < IN_CHANNELS; ic++) begin
        s0_smp_r[ic] <= (ic < PC) ? SAMPLE_BITS'($signed(f_smp[ic % PC])) : '0;
      end
    end
  end

  logic signed [SAMPLE_BITS-1:0] taps [NL];

  c3s_window #(
    .MAX_WIDTH(MAX_WIDTH), .IN_CHANNELS(IN_CHANNELS), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_window (
    .clk(clk), .rd_go(is_pix), .rd_col(col_r),
    .wr_go(s0_vld_r && en), .wr_col(s0_col_r),
    .samples(s0_smp_r), .taps(taps)
  );

  // sequencer: one output channel issued per cycle while the pipeline is enabled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_act_r <= 1'b0;
      oc_r      <= '0;
    end else if (en) begin
      if (is_pix && has_out) begin
        seq_act_r <= 1'b1;
        oc_r      <= '0;
      end else if (seq_act_r) begin
        seq_act_r <= !seq_last;
        oc_r      <= seq_last ? '0 : oc_r + OCW'(1);
      end
    end
  end

  // result tags along the lane pipeline
  c3s_pkg::tag_t  tag_r [1:4];
  logic [OCW-1:0] toc_r [1:4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 4; i++) tag_r[i] <= '0;
    end else if (en) begin
      tag_r[1].vld  <= seq_act_r;
      tag_r[1].last <= seq_last;
      for (int i = 2; i <= 4; i++) tag_r[i] <= tag_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      toc_r[1] <= oc_r;
      for (int i = 2; i <= 4; i++) toc_r[i] <= toc_r[i-1];
    end
  end

  // load ports shared by the lanes and the bias store
  logic [OCW-1:0]               wr_oc;
  logic signed [SAMPLE_BITS-1:0] coef;
  assign wr_oc = OCW'(f_toc);
  assign coef  = SAMPLE_BITS'($signed(f_coef));

  logic [SAMPLE_BITS-1:0] terms [NL];

  for (genvar ic = 0; ic < IN_CHANNELS; ic++) begin : g_ic
    for (genvar r = 0; r < c3s_pkg::KSIZE; r++) begin : g_r
      for (genvar c = 0; c < c3s_pkg::KSIZE; c++) begin : g_c
        localparam int L = ic*c3s_pkg::KTAPS + r*c3s_pkg::KSIZE + c;
        logic lane_we;
        assign lane_we = ld_w && (int'(f_tic) == ic) && (int'(f_tr) == r)
                         && (int'(f_tc) == c);
        c3s_lane #(.OUT_CHANNELS(OUT_CHANNELS), .SAMPLE_BITS(SAMPLE_BITS)) u_lane (
          .clk(clk), .en(en), .wr_en(lane_we), .wr_addr(wr_oc), .wr_data(coef),
          .rd_en(en && seq_act_r), .rd_addr(oc_r), .tap(taps[L]), .term(terms[L])
        );
      end
    end
  end

  logic [SAMPLE_BITS-1:0] total;

  c3s_merge #(
    .IN_CHANNELS(IN_CHANNELS), .OUT_CHANNELS(OUT_CHANNELS), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_merge (
    .clk(clk), .en(en), .wr_en(ld_b), .wr_addr(wr_oc), .wr_data(coef),
    .rd_en(en && seq_act_r), .rd_addr(oc_r), .terms(terms), .total(total)
  );

  // two-entry output buffer
  logic        push;
  logic        pop;
  logic        push_head;
  logic [15:0] feat;
  logic [3:0]  q_ch_r   [2];
  logic [15:0] q_feat_r [2];
  logic        q_last_r [2];

  assign feat      = 16'($signed(total));
  assign push      = en && tag_r[4].vld;
  assign pop       = out_tvalid && out_tready;
  assign push_head = push && (q_cnt_r == 2'd0 || (q_cnt_r == 2'd1 && pop));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // head slot takes a new result or moves up the second one
  always_ff @(posedge clk) begin
    if (push_head) begin
      q_ch_r[0]   <= 4'(toc_r[4]);
      q_feat_r[0] <= feat;
      q_last_r[0] <= tag_r[4].last;
    end else if (pop) begin
      q_ch_r[0]   <= q_ch_r[1];
      q_feat_r[0] <= q_feat_r[1];
      q_last_r[0] <= q_last_r[1];
    end
    if (push && !push_head) begin
      q_ch_r[1]   <= 4'(toc_r[4]);
      q_feat_r[1] <= feat;
      q_last_r[1] <= tag_r[4].last;
    end
  end

  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_tdata  = {4'd0, q_feat_r[0], q_ch_r[0]};
  assign out_tlast  = q_last_r[0];

endmodule

// ===== sv/c3s_checker.sv =====
// ----------------------------------------------------------------------------
// c3s_checker
// port-level checks of the convolution core, bound to the top level
// ----------------------------------------------------------------------------
`include "conv3x3_multichannel_stream_core_macros.svh"

module c3s_checker #(
  parameter int OUT_CHANNELS = c3s_pkg::DEF_OUT_CHANNELS
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tvalid,
  input logic        out_tready
);

  localparam logic [3:0] LAST_CH = 4'((OUT_CHANNELS - 1) % 16);

  // reset empties the result buffer
  `C3S_ASSERT_NEXT(a_rst_empty, clk, !rst_n, !out_tvalid)

  // a stalled result beat stays offered
  `C3S_ASSERT_NEXT(a_out_hold, clk, rst_n && out_tvalid && !out_tready, out_tvalid)

  // the pixel end mark sits on the final output channel
  `C3S_ASSERT_NOW(a_last_ch, clk, rst_n, out_tvalid && out_tlast, out_tdata[3:0] == LAST_CH)

endmodule

bind conv3x3_multichannel_stream_core c3s_checker #(.OUT_CHANNELS(OUT_CHANNELS)) u_c3s_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tvalid(out_tvalid),
  .out_tready(out_tready)
);
